[rtl/lbf_pkg.sv]
// ----------------------------------------------------------------------------
// lbf_pkg
// Shared types and constants for the learning bridge forwarder.
// ----------------------------------------------------------------------------
package lbf_pkg;

  localparam int MAX_PORTS = 8;
  localparam int MAX_LINKS = 8;
  localparam int ADDR_BITS = 8;

  // Fixed field widths of the item and result channels.
  localparam int FLAG_W  = 1;
  localparam int INDEX_W = 3;
  localparam int ADDR_W  = 8;
  localparam int MASK_W  = 8;

  // Address bits that take part in a compare.
  localparam int CMP_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  // Index into the learned table.
  localparam int PIDX_W = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  // Wide enough for the port and link counts and the largest maximum.
  localparam int CNT_W = 6;

  // Configuration port.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int PORTS_W    = 4;
  localparam int LINKS_W    = 4;

  typedef enum logic [1:0] {
    REG_ACTIVE_PORTS      = 2'd0,
    REG_ACTIVE_LINKS      = 2'd1,
    REG_BROADCAST_ADDRESS = 2'd2
  } reg_index_t;

  localparam logic [PORTS_W-1:0] ACTIVE_PORTS_RESET = 4'd8;
  localparam logic [LINKS_W-1:0] ACTIVE_LINKS_RESET = 4'd0;
  localparam logic [ADDR_W-1:0]  BROADCAST_RESET    = 8'd99;

  typedef struct packed {
    logic [PORTS_W-1:0] active_ports;
    logic [LINKS_W-1:0] active_links;
    logic [ADDR_W-1:0]  broadcast_address;
  } cfg_t;

  typedef struct packed {
    logic [FLAG_W-1:0]  from_link;
    logic [INDEX_W-1:0] arrival_index;
    logic [ADDR_W-1:0]  dest_address;
    logic [ADDR_W-1:0]  source_address;
  } hdr_t;

  typedef struct packed {
    logic              learn;
    logic [MASK_W-1:0] port_mask;
    logic [MASK_W-1:0] link_mask;
  } decision_t;

  typedef logic [MAX_PORTS-1:0][CMP_W-1:0] addr_tbl_t;

endpackage

[rtl/lbf_if.sv]
// ----------------------------------------------------------------------------
// lbf_hdr_if / lbf_mask_if
// Valid/ready channels for frame header items and forwarding result items.
// ----------------------------------------------------------------------------
interface lbf_hdr_if import lbf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FLAG_W-1:0]  from_link;
  logic [INDEX_W-1:0] arrival_index;
  logic [ADDR_W-1:0]  dest_address;
  logic [ADDR_W-1:0]  source_address;

  modport source (
    output valid, from_link, arrival_index, dest_address, source_address,
    input  ready
  );
  modport sink (
    input  valid, from_link, arrival_index, dest_address, source_address,
    output ready
  );
endinterface

interface lbf_mask_if import lbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] port_mask;
  logic [MASK_W-1:0] link_mask;

  modport source (
    output valid, port_mask, link_mask,
    input  ready
  );
  modport sink (
    input  valid, port_mask, link_mask,
    output ready
  );
endinterface

[rtl/learning_bridge_forwarder_core.sv]
// ----------------------------------------------------------------------------
// learning_bridge_forwarder_core
// Learning bridge forwarder: learns port source addresses and returns the
// port and link masks for each frame header item.
// ----------------------------------------------------------------------------
//  channel  | kind       | payload
//  ---------+------------+---------------------------------------------------
//  hdr      | item in    | from_link, arrival_index, dest_address, source_address
//  res      | item out   | port_mask, link_mask
//  apb      | registers  | active_ports @0x0, active_links @0x4, broadcast @0x8
//
// One item per cycle while results are taken: input register, decision logic,
// result register; an accepted item is valid once in the result register.
// The learned table is written as an item moves into the result register.
// A stalled result holds both stages; the input register still takes an
// item while the result register is full if it is itself empty.
// Reset clears the learned valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module learning_bridge_forwarder_core import lbf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  lbf_hdr_if.sink               hdr,
  lbf_mask_if.source            res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t                 cfg;
  hdr_t                 s1;
  logic                 s1_valid;
  logic                 out_valid;
  logic                 out_free;
  decision_t            dec;
  addr_tbl_t            learned_address;
  logic [MAX_PORTS-1:0] learned_valid;
  logic [MASK_W-1:0]    port_mask;
  logic [MASK_W-1:0]    link_mask;
  logic [PIDX_W-1:0]    learn_idx;

  lbf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lbf_decide u_decide (
    .cfg             (cfg),
    .hdr             (s1),
    .learned_address (learned_address),
    .learned_valid   (learned_valid),
    .dec             (dec)
  );

  assign out_free  = !out_valid || res.ready;
  assign hdr.ready = !s1_valid || out_free;
  assign learn_idx = PIDX_W'(s1.arrival_index);

  assign res.valid     = out_valid;
  assign res.port_mask = port_mask;
  assign res.link_mask = link_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      learned_valid <= '0;
    end else begin
      if (hdr.ready) begin
        s1_valid <= hdr.valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
        if (s1_valid && dec.learn) begin
          learned_valid[learn_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.ready) begin
      s1.from_link      <= hdr.from_link;
      s1.arrival_index  <= hdr.arrival_index;
      s1.dest_address   <= hdr.dest_address;
      s1.source_address <= hdr.source_address;
    end
    if (out_free && s1_valid) begin
      port_mask <= dec.port_mask;
      link_mask <= dec.link_mask;
      if (dec.learn) begin
        learned_address[learn_idx] <= s1.source_address[CMP_W-1:0];
      end
    end
  end

endmodule

[rtl/lbf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lbf_cfg_regs
// APB-style register file holding port count, link count and broadcast address.
// ----------------------------------------------------------------------------
module lbf_cfg_regs import lbf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_index_t reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_ports      <= ACTIVE_PORTS_RESET;
      cfg.active_links      <= ACTIVE_LINKS_RESET;
      cfg.broadcast_address <= BROADCAST_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ACTIVE_PORTS:      cfg.active_ports      <= pwdata[PORTS_W-1:0];
        REG_ACTIVE_LINKS:      cfg.active_links      <= pwdata[LINKS_W-1:0];
        REG_BROADCAST_ADDRESS: cfg.broadcast_address <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ACTIVE_PORTS:      prdata = APB_DATA_W'(cfg.active_ports);
      REG_ACTIVE_LINKS:      prdata = APB_DATA_W'(cfg.active_links);
      REG_BROADCAST_ADDRESS: prdata = APB_DATA_W'(cfg.broadcast_address);
      default:               prdata = '0;
    endcase
  end

endmodule

[rtl/lbf_decide.sv]
// ----------------------------------------------------------------------------
// lbf_decide
// Forwarding decision for one header against the learned port addresses.
// ----------------------------------------------------------------------------
module lbf_decide import lbf_pkg::*; (
  input  cfg_t                 cfg,
  input  hdr_t                 hdr,
  input  addr_tbl_t            learned_address,
  input  logic [MAX_PORTS-1:0] learned_valid,
  output decision_t            dec
);

  logic [CNT_W-1:0]     num_ports;
  logic [CNT_W-1:0]     num_links;
  logic [CNT_W-1:0]     idx;
  logic                 link;
  logic                 active;
  logic                 is_bcast;
  logic [CMP_W-1:0]     dest;
  logic [CMP_W-1:0]     src;
  logic [MAX_PORTS-1:0] pmask;
  logic [MAX_LINKS-1:0] lmask;
  logic                 own;
  logic                 vld;
  logic [CMP_W-1:0]     addr;

  always_comb begin
    num_ports = (CNT_W'(cfg.active_ports) > CNT_W'(MAX_PORTS)) ?
                CNT_W'(MAX_PORTS) : CNT_W'(cfg.active_ports);
    num_links = (CNT_W'(cfg.active_links) > CNT_W'(MAX_LINKS)) ?
                CNT_W'(MAX_LINKS) : CNT_W'(cfg.active_links);
    idx      = CNT_W'(hdr.arrival_index);
    link     = hdr.from_link[0];
    dest     = hdr.dest_address[CMP_W-1:0];
    src      = hdr.source_address[CMP_W-1:0];
    active   = link ? (idx < num_links) : (idx < num_ports);
    is_bcast = dest == cfg.broadcast_address[CMP_W-1:0];

    // The arriving port learns its source before the lookup, so its own
    // entry is taken from the header rather than the table.
    pmask = '0;
    for (int k = 0; k < MAX_PORTS; k++) begin
      own  = !link && (idx == CNT_W'(k));
      vld  = learned_valid[k] || own;
      addr = own ? src : learned_address[k];
      if (CNT_W'(k) < num_ports) begin
        if (is_bcast) begin
          pmask[k] = link || !own;
        end else begin
          pmask[k] = vld && (addr == dest);
        end
      end
    end

    lmask = '0;
    if (is_bcast || (pmask == '0)) begin
      for (int l = 0; l < MAX_LINKS; l++) begin
        lmask[l] = (CNT_W'(l) < num_links) && (!link || idx != CNT_W'(l));
      end
    end

    dec.learn     = active && !link;
    dec.port_mask = active ? MASK_W'(pmask) : '0;
    dec.link_mask = active ? MASK_W'(lmask) : '0;
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the learning bridge forwarder. Frame header items
// go in through a queue-fed driver; a monitor compares each mask item with a
// prediction made when its header was accepted. Random idling runs on both
// sides, with a receiver stall in one phase; the registers change between phases.
// ----------------------------------------------------------------------------
module testbench import lbf_pkg::*; ();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_COUNT  = 9;
  localparam int PHASE_ITEMS  = 150;
  localparam int STALL_PHASE  = 3;
  localparam int STEADY_PHASE = 4;

  typedef struct packed {
    logic [MASK_W-1:0] port_mask;
    logic [MASK_W-1:0] link_mask;
  } fwd_t;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lbf_hdr_if  hdr_ch ();
  lbf_mask_if res_ch ();

  learning_bridge_forwarder_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .hdr     (hdr_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the register file and the learned table.
  logic [PORTS_W-1:0] ports_cfg = ACTIVE_PORTS_RESET;
  logic [LINKS_W-1:0] links_cfg = ACTIVE_LINKS_RESET;
  logic [ADDR_W-1:0]  bcast_cfg = BROADCAST_RESET;
  logic [CMP_W-1:0]   learned_addr [MAX_PORTS];
  logic               learned_vld  [MAX_PORTS];

  hdr_t        pending_hdrs [$];
  fwd_t        fwd_expect   [$];
  hdr_t        next_hdr;
  hdr_t        taken_hdr;
  fwd_t        want;
  logic [7:0]  addr_pool [8];
  int          send_idle_pct = 38;
  int          recv_idle_pct = 38;
  int          stall_left    = 0;
  int          err_count     = 0;
  int          cycle_count   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int port_count();
    return (ports_cfg > MAX_PORTS) ? MAX_PORTS : int'(ports_cfg);
  endfunction

  function automatic int link_count();
    return (links_cfg > MAX_LINKS) ? MAX_LINKS : int'(links_cfg);
  endfunction

  // Learns the source of a port frame and returns where the frame goes.
  function automatic fwd_t forward_masks(input hdr_t h);
    fwd_t r;
    int   np;
    int   nl;
    int   idx;
    r   = '0;
    np  = port_count();
    nl  = link_count();
    idx = int'(h.arrival_index);
    if (h.from_link ? (idx >= nl) : (idx >= np)) return r;
    if (!h.from_link) begin
      learned_addr[idx] = h.source_address[CMP_W-1:0];
      learned_vld[idx]  = 1'b1;
    end
    if (h.dest_address[CMP_W-1:0] == bcast_cfg[CMP_W-1:0]) begin
      for (int k = 0; k < np; k++)
        if (h.from_link || k != idx) r.port_mask[k] = 1'b1;
      for (int k = 0; k < nl; k++)
        if (!h.from_link || k != idx) r.link_mask[k] = 1'b1;
    end else begin
      for (int k = 0; k < np; k++)
        if (learned_vld[k] && learned_addr[k] == h.dest_address[CMP_W-1:0])
          r.port_mask[k] = 1'b1;
      if (r.port_mask == '0) begin
        for (int k = 0; k < nl; k++)
          if (!h.from_link || k != idx) r.link_mask[k] = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      hdr_ch.valid <= 1'b0;
    end else begin
      if (hdr_ch.valid && hdr_ch.ready) begin
        taken_hdr = {hdr_ch.from_link, hdr_ch.arrival_index,
                     hdr_ch.dest_address, hdr_ch.source_address};
        fwd_expect.push_back(forward_masks(taken_hdr));
      end
      if (!hdr_ch.valid || hdr_ch.ready) begin
        if (pending_hdrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_hdr = pending_hdrs.pop_front();
          hdr_ch.valid          <= 1'b1;
          hdr_ch.from_link      <= next_hdr.from_link;
          hdr_ch.arrival_index  <= next_hdr.arrival_index;
          hdr_ch.dest_address   <= next_hdr.dest_address;
          hdr_ch.source_address <= next_hdr.source_address;
        end else begin
          hdr_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (fwd_expect.size() == 0) begin
          err_count++;
          $error("unexpected result item: port_mask %02h link_mask %02h",
                 res_ch.port_mask, res_ch.link_mask);
        end else begin
          want = fwd_expect.pop_front();
          if (res_ch.port_mask !== want.port_mask) begin
            err_count++;
            $error("port_mask: expected %02h, got %02h", want.port_mask, res_ch.port_mask);
          end
          if (res_ch.link_mask !== want.link_mask) begin
            err_count++;
            $error("link_mask: expected %02h, got %02h", want.link_mask, res_ch.link_mask);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic program_reg(input reg_index_t r, input logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(r));
    pwdata  <= v | ($urandom() & 32'hFFFF_FF00);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_ACTIVE_PORTS:      ports_cfg = v[PORTS_W-1:0];
      REG_ACTIVE_LINKS:      links_cfg = v[LINKS_W-1:0];
      REG_BROADCAST_ADDRESS: bcast_cfg = v[ADDR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_hdr(input logic fl, input logic [2:0] idx,
                          input logic [7:0] dst, input logic [7:0] src);
    pending_hdrs.push_back({fl, idx, dst, src});
  endtask

  // Waits until every queued header is accepted and every result is back.
  task automatic settle();
    do @(negedge clk);
    while (pending_hdrs.size() != 0 || hdr_ch.valid || fwd_expect.size() != 0);
  endtask

  // Mostly active arrivals and addresses from a small pool, so that learned
  // entries are hit often; the rest is arbitrary.
  task automatic push_random_hdr();
    hdr_t h;
    int   lim;
    int   roll;
    h.from_link = (links_cfg != 0) ? ($urandom_range(99) < 40) : ($urandom_range(99) < 10);
    lim = h.from_link ? link_count() : port_count();
    if (lim != 0 && $urandom_range(99) < 85) h.arrival_index = 3'($urandom_range(lim - 1));
    else h.arrival_index = 3'($urandom_range(7));
    roll = $urandom_range(99);
    if (roll < 15) h.dest_address = bcast_cfg;
    else if (roll < 75) h.dest_address = addr_pool[$urandom_range(7)];
    else h.dest_address = 8'($urandom_range(255));
    if ($urandom_range(99) < 70) h.source_address = addr_pool[$urandom_range(7)];
    else h.source_address = 8'($urandom_range(255));
    pending_hdrs.push_back(h);
  endtask

  initial begin
    int ports_plan [PHASE_COUNT];
    int links_plan [PHASE_COUNT];
    int bcast_plan [PHASE_COUNT];
    int waited;
    ports_plan = '{8, 1, 15, 8, 3, 0, 9, 0, 0};
    links_plan = '{8, 0, 15, 8, 5, 8, 1, 0, 0};
    bcast_plan = '{99, 0, 255, 0, 0, 0, 0, 0, 0};
    hdr_ch.valid          = 1'b0;
    hdr_ch.from_link      = '0;
    hdr_ch.arrival_index  = '0;
    hdr_ch.dest_address   = '0;
    hdr_ch.source_address = '0;
    res_ch.ready          = 1'b0;
    for (int k = 0; k < MAX_PORTS; k++) begin
      learned_addr[k] = '0;
      learned_vld[k]  = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: eight ports, no links.
    send_hdr(1'b0, 3'd1, 8'h00, 8'h22);  // unlearned entries never match, not even a zero destination
    send_hdr(1'b1, 3'd0, 8'd99, 8'h55);  // no link is active, so this is dropped
    send_hdr(1'b0, 3'd0, 8'd99, 8'h11);
    settle();
    program_reg(REG_ACTIVE_LINKS, 32'd8);
    send_hdr(1'b0, 3'd7, 8'h22, 8'hFF);
    send_hdr(1'b0, 3'd3, 8'h00, 8'h00);  // destination is the sender's own source
    send_hdr(1'b0, 3'd2, 8'h11, 8'h11);
    send_hdr(1'b1, 3'd0, 8'd99, 8'h00);  // a link broadcast reaches every port
    send_hdr(1'b1, 3'd7, 8'h11, 8'hFF);
    send_hdr(1'b1, 3'd5, 8'hAB, 8'h12);
    send_hdr(1'b0, 3'd4, 8'hAB, 8'h80);
    send_hdr(1'b0, 3'd6, 8'hFF, 8'h7F);
    send_hdr(1'b1, 3'd3, 8'h80, 8'h00);
    settle();
    program_reg(REG_ACTIVE_PORTS, 32'd3);
    program_reg(REG_BROADCAST_ADDRESS, 32'd0);
    send_hdr(1'b0, 3'd3, 8'h11, 8'h44);
    send_hdr(1'b0, 3'd2, 8'h00, 8'h01);
    send_hdr(1'b1, 3'd2, 8'h00, 8'hFF);
    send_hdr(1'b0, 3'd0, 8'h11, 8'h33);
    settle();
    program_reg(REG_ACTIVE_PORTS, 32'd0);
    program_reg(REG_ACTIVE_LINKS, 32'd15);
    program_reg(REG_BROADCAST_ADDRESS, 32'd255);
    send_hdr(1'b0, 3'd0, 8'hFF, 8'h01);
    send_hdr(1'b1, 3'd7, 8'hFF, 8'h02);
    send_hdr(1'b1, 3'd0, 8'h22, 8'h03);
    settle();
    program_reg(REG_ACTIVE_PORTS, 32'd15);
    program_reg(REG_ACTIVE_LINKS, 32'd1);
    send_hdr(1'b0, 3'd7, 8'hFF, 8'hFF);
    send_hdr(1'b1, 3'd0, 8'hFF, 8'h00);
    send_hdr(1'b1, 3'd1, 8'hFF, 8'h00);
    send_hdr(1'b0, 3'd5, 8'hFF, 8'hFF);
    settle();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph >= 7) begin
        ports_plan[ph] = $urandom_range(1, 8);
        links_plan[ph] = $urandom_range(0, 8);
      end
      if (ph >= 3) bcast_plan[ph] = $urandom_range(255);
      program_reg(REG_ACTIVE_PORTS, 32'(ports_plan[ph]));
      program_reg(REG_ACTIVE_LINKS, 32'(links_plan[ph]));
      program_reg(REG_BROADCAST_ADDRESS, 32'(bcast_plan[ph]));
      for (int k = 0; k < 8; k++) addr_pool[k] = 8'($urandom_range(255));
      send_idle_pct = 38;
      recv_idle_pct = 38;
      if (ph == STALL_PHASE) begin
        // Receiver holds off while the sender keeps offering items.
        send_idle_pct = 0;
        stall_left    = 300;
      end
      if (ph == STEADY_PHASE) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) push_random_hdr();
      settle();
    end

    do @(negedge clk);
    while (pending_hdrs.size() != 0 || hdr_ch.valid);
    waited = 0;
    while (fwd_expect.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (fwd_expect.size() != 0) begin
      err_count++;
      $error("%0d expected result items never arrived", fwd_expect.size());
    end
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
